// File: src/mips_subset_execute_core_defines.svh
`ifndef MIPS_SUBSET_EXECUTE_CORE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication
`define MSEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/msec_pkg.sv
package msec_pkg;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_SLT     = 6'd42;

	localparam logic [4:0] RS_SRL  = 5'd0;
	localparam logic [4:0] RS_ROTR = 5'd1;
	localparam logic [4:0] REG_RA  = 5'd31;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO  = 3'd2;
	localparam logic [2:0] ST_BADJUMP  = 3'd3;
	localparam logic [2:0] ST_HALTED   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_DIV, S_MEM, S_LOAD, S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic exec;
		logic mul_fin;
		logic div_step;
		logic mem;
		logic load_fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_mul;
		logic is_div;
		logic is_mem;
		logic is_lw;
		logic need_mod;
		logic div_last;
	} dp_stat_t;

endpackage

// File: src/mips_subset_execute_core.sv
// Most instructions go from accepted beat to result through the accept, execute and output steps.
// MULT adds a finishing step; DIV with a nonzero divisor goes through the shared radix-2 divider.
// LW/SW add a memory step (LW also a load step); with a non-power-of-two DATA_WORDS the address also takes the divider.
// Throughput: one instruction at a time; the next beat is taken once the result is registered.
// Reset: asynchronous, active low; afterwards every data memory word is cleared while input stalls.
module mips_subset_execute_core #(
	parameter int DATA_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_fetch_addr,
	output logic [2:0]  status,
	output logic        reg_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);
	import msec_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	msec_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	msec_datapath #(.DATA_WORDS(DATA_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .instr_word(instr_word),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.next_fetch_addr(next_fetch_addr), .status(status), .reg_written(reg_written),
		.dest_index(dest_index), .dest_value(dest_value)
	);
endmodule

// File: src/msec_ram.sv
module msec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/msec_ctrl.sv
`include "mips_subset_execute_core_defines.svh"
module msec_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  msec_pkg::dp_stat_t stat,
	output msec_pkg::cmd_t    cmd
);
	import msec_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_mul) state_d = S_MUL;
				else if (stat.is_div) state_d = S_DIV;
				else if (stat.is_mem) state_d = stat.need_mod ? S_DIV : S_MEM;
				else state_d = S_OUT;
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_d     = S_OUT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = stat.is_mem ? S_MEM : S_OUT;
			end
			S_MEM: begin
				cmd.mem = 1'b1;
				state_d = stat.is_lw ? S_LOAD : S_OUT;
			end
			S_LOAD: begin
				cmd.load_fin = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`MSEC_ASSERT_NEXT(a_accept_exec, cmd.load, state_q == S_EXEC, "accepted beat not executed")
	`MSEC_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_q || !out_stall, "result overwrote beat")
	`MSEC_ASSERT_NOW(a_clear_stall, state_q == S_CLEAR, in_stall, "input taken during clear")
endmodule

// File: src/msec_datapath.sv
module msec_datapath #(
	parameter int DATA_WORDS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  msec_pkg::cmd_t     cmd,
	output msec_pkg::dp_stat_t stat,
	input  logic [31:0]        instr_word,
	input  logic               cfg_we,
	input  logic [11:0]        cfg_data,
	output logic [31:0]        next_fetch_addr,
	output logic [2:0]         status,
	output logic               reg_written,
	output logic [4:0]         dest_index,
	output logic [31:0]        dest_value
);
	import msec_pkg::*;

	localparam int AW = $clog2(DATA_WORDS);
	localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
	localparam logic [31:0] DW32 = 32'(DATA_WORDS);

	logic [31:0] instr_q, pc_q, hi_q, lo_q, bd_q;
	logic        bp_q, halt_q;
	logic [11:0] plw_q;
	logic [31:0] gvld_q;
	logic [AW-1:0] clr_q, addr_q;
	logic [31:0] res_next_q, res_val_q;
	logic [2:0]  res_status_q;
	logic        res_wr_q;
	logic [4:0]  res_idx_q;
	logic signed [63:0] prod_s1;
	logic [31:0] dvd_q, dvs_q, rem_q;
	logic [4:0]  dcnt_q;
	logic        qneg_q, rneg_q;

	logic [5:0]  prim, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [15:0] imm;
	logic [25:0] jidx;
	logic [4:0]  ra_addr, rb_addr;
	logic [31:0] rda, rdb, va, vb, seq, lim, sext, sum, diff, addi, maddr;
	logic [33:0] bt;
	logic        in_slot, cond, is_special;
	logic [31:0] ex_next, ex_dest, ex_val;
	logic [2:0]  ex_status;
	logic        ex_wr, ex_take, ex_halt, ex_hilo_clr;
	logic [4:0]  ex_idx;
	logic        gwe;
	logic [4:0]  gwa;
	logic [31:0] gwd, dram_rd;
	logic [32:0] dsh;
	logic        dge;
	logic [31:0] rem_n, dvd_n;
	logic        dwe;
	logic [AW-1:0] dwa;

	assign prim = instr_q[31:26];
	assign rs   = instr_q[25:21];
	assign rt   = instr_q[20:16];
	assign rd   = instr_q[15:11];
	assign sh   = instr_q[10:6];
	assign fn   = instr_q[5:0];
	assign imm  = instr_q[15:0];
	assign jidx = instr_q[25:0];

	assign ra_addr = cmd.load ? instr_word[25:21] : rs;
	assign rb_addr = cmd.load ? instr_word[20:16] : rt;

	msec_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
		.clk(clk), .we(gwe), .waddr(gwa), .wdata(gwd), .raddr(ra_addr), .rdata(rda)
	);
	msec_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
		.clk(clk), .we(gwe), .waddr(gwa), .wdata(gwd), .raddr(rb_addr), .rdata(rdb)
	);

	assign dwe = cmd.clr || (cmd.mem && (prim == OP_SW));
	assign dwa = cmd.clr ? clr_q : addr_q;

	msec_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk(clk), .we(dwe), .waddr(dwa), .wdata(cmd.clr ? 32'd0 : vb),
		.raddr(addr_q), .rdata(dram_rd)
	);

	assign va      = gvld_q[rs] ? rda : 32'd0;
	assign vb      = gvld_q[rt] ? rdb : 32'd0;
	assign seq     = pc_q + 32'd4;
	assign lim     = {18'd0, plw_q, 2'b00};
	assign sext    = {{16{imm[15]}}, imm};
	assign sum     = va + vb;
	assign diff    = va - vb;
	assign addi    = va + sext;
	assign maddr   = va + sext;
	assign bt      = {2'b00, seq} + {{16{imm[15]}}, imm, 2'b00};
	assign in_slot = bp_q;
	assign is_special = (prim == OP_SPECIAL);

	always_comb begin
		unique case (prim)
			OP_BEQ:  cond = (va == vb);
			OP_BNE:  cond = (va != vb);
			OP_BLEZ: cond = va[31] || (va == 32'd0);
			default: cond = !va[31] && (va != 32'd0);
		endcase
	end

	always_comb begin
		ex_status   = ST_OK;
		ex_wr       = 1'b0;
		ex_idx      = rd;
		ex_val      = 32'd0;
		ex_take     = 1'b0;
		ex_dest     = 32'd0;
		ex_halt     = 1'b0;
		ex_hilo_clr = 1'b0;
		unique case (prim)
			OP_SPECIAL: begin
				unique case (fn)
					FN_ADD: begin
						if ((va[31] == vb[31]) && (sum[31] != va[31])) ex_status = ST_OVERFLOW;
						else begin
							ex_wr  = 1'b1;
							ex_val = sum;
						end
					end
					FN_SUB: begin
						if ((va[31] != vb[31]) && (diff[31] != va[31])) ex_status = ST_OVERFLOW;
						else begin
							ex_wr  = 1'b1;
							ex_val = diff;
						end
					end
					FN_AND: begin ex_wr = 1'b1; ex_val = va & vb; end
					FN_OR:  begin ex_wr = 1'b1; ex_val = va | vb; end
					FN_XOR: begin ex_wr = 1'b1; ex_val = va ^ vb; end
					FN_SLT: begin
						ex_wr  = 1'b1;
						ex_val = {31'd0, $signed(va) < $signed(vb)};
					end
					FN_DIV: begin
						if (vb == 32'd0) begin
							ex_status   = ST_DIVZERO;
							ex_hilo_clr = 1'b1;
						end
					end
					FN_MULT: ;
					FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_q; end
					FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_q; end
					FN_SLL:  begin ex_wr = 1'b1; ex_val = vb << sh; end
					FN_SRL: begin
						if (rs == RS_SRL) begin
							ex_wr  = 1'b1;
							ex_val = vb >> sh;
						end else if (rs == RS_ROTR) begin
							ex_wr  = 1'b1;
							ex_val = (sh == 5'd0) ? vb : ((vb >> sh) | (vb << (6'd32 - {1'b0, sh})));
						end else begin
							ex_status = ST_UNKNOWN;
						end
					end
					FN_JR: begin
						if (!in_slot) begin
							if (va[31] || (va > lim)) ex_status = ST_BADJUMP;
							else begin
								ex_take = 1'b1;
								ex_dest = va;
							end
						end
					end
					FN_SYSCALL: begin
						ex_halt   = 1'b1;
						ex_status = ST_HALTED;
					end
					default: ex_status = ST_UNKNOWN;
				endcase
			end
			OP_ADDI: begin
				ex_idx = rt;
				if ((va[31] == imm[15]) && (addi[31] != va[31])) ex_status = ST_OVERFLOW;
				else begin
					ex_wr  = 1'b1;
					ex_val = addi;
				end
			end
			OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
				if (!in_slot && cond) begin
					if (bt[33] || bt[32] || (bt[31:0] > lim)) ex_status = ST_BADJUMP;
					else begin
						ex_take = 1'b1;
						ex_dest = bt[31:0];
					end
				end
			end
			OP_LUI: begin
				ex_idx = rt;
				ex_wr  = 1'b1;
				ex_val = {imm, 16'd0};
			end
			OP_LW, OP_SW: ;
			OP_J, OP_JAL: begin
				ex_idx = REG_RA;
				if (!in_slot) begin
					if (jidx > {14'd0, plw_q}) ex_status = ST_BADJUMP;
					else begin
						ex_take = 1'b1;
						ex_dest = {seq[31:28], jidx, 2'b00};
						if (prim == OP_JAL) begin
							ex_wr  = 1'b1;
							ex_val = seq + 32'd4;
						end
					end
				end
			end
			default: ex_status = ST_UNKNOWN;
		endcase
		if (ex_idx == 5'd0) ex_wr = 1'b0;
		if (halt_q) begin
			ex_status   = ST_HALTED;
			ex_wr       = 1'b0;
			ex_take     = 1'b0;
			ex_halt     = 1'b0;
			ex_hilo_clr = 1'b0;
		end
		if (halt_q) ex_next = pc_q;
		else if (ex_halt) ex_next = seq;
		else if (in_slot) ex_next = bd_q;
		else ex_next = seq;
	end

	assign stat.clr_last = (clr_q == AW'(DATA_WORDS - 1));
	assign stat.is_mul   = !halt_q && is_special && (fn == FN_MULT);
	assign stat.is_div   = !halt_q && is_special && (fn == FN_DIV) && (vb != 32'd0);
	assign stat.is_mem   = !halt_q && ((prim == OP_LW) || (prim == OP_SW));
	assign stat.is_lw    = (prim == OP_LW);
	assign stat.need_mod = !IS_POW2;
	assign stat.div_last = (dcnt_q == 5'd31);

	assign dsh   = {rem_q, dvd_q[31]};
	assign dge   = dsh >= {1'b0, dvs_q};
	assign rem_n = dge ? 32'(dsh - {1'b0, dvs_q}) : dsh[31:0];
	assign dvd_n = {dvd_q[30:0], dge};

	assign gwe = (cmd.exec && ex_wr) || (cmd.load_fin && (rt != 5'd0));
	assign gwa = cmd.load_fin ? rt : ex_idx;
	assign gwd = cmd.load_fin ? dram_rd : ex_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 32'd0;
			hi_q   <= 32'd0;
			lo_q   <= 32'd0;
			bd_q   <= 32'd0;
			bp_q   <= 1'b0;
			halt_q <= 1'b0;
			plw_q  <= 12'd0;
			gvld_q <= 32'd0;
			clr_q  <= '0;
			dcnt_q <= 5'd0;
		end else begin
			if (cfg_we) plw_q <= cfg_data;
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (gwe) gvld_q[gwa] <= 1'b1;
			if (cmd.exec) begin
				dcnt_q <= 5'd0;
				pc_q   <= ex_next;
				if (!halt_q) begin
					if (ex_halt) begin
						halt_q <= 1'b1;
						bp_q   <= 1'b0;
					end else if (ex_take) begin
						bp_q <= 1'b1;
						bd_q <= ex_dest;
					end else if (in_slot) begin
						bp_q <= 1'b0;
					end
				end
				if (ex_hilo_clr) begin
					hi_q <= 32'd0;
					lo_q <= 32'd0;
				end
			end
			if (cmd.mul_fin) begin
				hi_q <= prod_s1[63:32];
				lo_q <= prod_s1[31:0];
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (stat.div_last && !stat.is_mem) begin
					lo_q <= qneg_q ? (32'd0 - dvd_n) : dvd_n;
					hi_q <= rneg_q ? (32'd0 - rem_n) : rem_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) instr_q <= instr_word;
		if (cmd.exec) begin
			prod_s1      <= $signed(va) * $signed(vb);
			addr_q       <= maddr[AW-1:0];
			res_next_q   <= ex_next;
			res_status_q <= ex_status;
			res_wr_q     <= ex_wr;
			res_idx_q    <= ex_wr ? ex_idx : 5'd0;
			res_val_q    <= ex_wr ? ex_val : 32'd0;
			rem_q        <= 32'd0;
			if (stat.is_mem) begin
				dvd_q  <= maddr;
				dvs_q  <= DW32;
				qneg_q <= 1'b0;
				rneg_q <= 1'b0;
			end else begin
				dvd_q  <= va[31] ? (32'd0 - va) : va;
				dvs_q  <= vb[31] ? (32'd0 - vb) : vb;
				qneg_q <= va[31] ^ vb[31];
				rneg_q <= va[31];
			end
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
			if (stat.div_last && stat.is_mem) addr_q <= rem_n[AW-1:0];
		end
		if (cmd.load_fin) begin
			res_wr_q  <= (rt != 5'd0);
			res_idx_q <= rt;
			res_val_q <= (rt != 5'd0) ? dram_rd : 32'd0;
		end
		if (cmd.out_load) begin
			next_fetch_addr <= res_next_q;
			status          <= res_status_q;
			reg_written     <= res_wr_q;
			dest_index      <= res_idx_q;
			dest_value      <= res_val_q;
		end
	end
endmodule
